// ===== hdl/tem_pkg.sv =====
// Shared types and constants for the timestamp event matcher.
// Used by tem_cell, tem_ctrl and timestamp_event_matcher; depends on nothing.
package tem_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam logic [31:0] MATCH_WINDOW_RST = 32'd80000;

    // request type codes
    localparam logic [1:0] REQ_SOURCE = 2'd0;
    localparam logic [1:0] REQ_RENDER = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT_ONLY = 1'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] timestamp_us;
        logic        context_allowed;
        logic        player_moving;
        logic        moved_recently;
    } t_tem_req;

    typedef struct packed {
        logic        admitted;
        logic        queue_full_drop;
        logic        matched;
        logic [31:0] match_delta_us;
        logic [4:0]  expired_now;
        logic [4:0]  pending_after;
        logic [31:0] matched_total;
        logic [31:0] expired_total;
        logic [31:0] unmatched_total;
    } t_tem_rsp;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic        shift;   // drop the entry at the remove position, close the gap
        logic        write;   // store now at the tail position
        logic [63:0] now;
        logic [31:0] window;
    } t_cell_ctl;

    // best-candidate token handed from cell to cell
    typedef struct packed {
        logic        found;
        logic [31:0] delta;
    } t_tok;

endpackage

// ===== hdl/tem_cell.sv =====
// One queue position: holds a pending stamp, classifies it against now,
// and folds it into the best-candidate token passed along the chain. Uses tem_pkg.
module tem_cell #(
    parameter  int unsigned DEPTH = tem_pkg::QUEUE_DEPTH_DEF,
    parameter  int unsigned POS   = 0,
    localparam int unsigned IDX_W = $clog2(DEPTH),
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  tem_pkg::t_cell_ctl   i_ctl,
    input  logic [CNT_W-1:0]     i_cnt,
    input  logic [IDX_W-1:0]     i_rm_pos,
    input  logic [63:0]          i_next_stamp,
    output logic [63:0]          o_stamp,
    output logic                 o_old,
    input  tem_pkg::t_tok        i_tok,
    input  logic [IDX_W-1:0]     i_tok_idx,
    output tem_pkg::t_tok        o_tok,
    output logic [IDX_W-1:0]     o_tok_idx
);

    logic [63:0]      r_stamp;
    logic             r_old;
    logic             r_qual;
    logic [31:0]      r_d;
    tem_pkg::t_tok    r_tok;
    logic [IDX_W-1:0] r_idx;

    logic [64:0]      w_diff;
    logic             w_live;
    logic             w_near;
    logic             w_take;

    always_comb begin
        w_diff = {1'b0, i_ctl.now} - {1'b0, r_stamp};
        w_live = (CNT_W'(POS) < i_cnt) && (r_stamp != 64'd0) && !w_diff[64];
        w_near = (w_diff[63:32] == 32'd0) && (w_diff[31:0] <= i_ctl.window);
        w_take = r_qual && (!i_tok.found || (r_d < i_tok.delta));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && (IDX_W'(POS) >= i_rm_pos)) begin
            r_stamp <= i_next_stamp;
        end else if (i_ctl.write && (CNT_W'(POS) == i_cnt)) begin
            r_stamp <= i_ctl.now;
        end
        r_old  <= w_live && !w_near;
        r_qual <= w_live && w_near;
        r_d    <= w_diff[31:0];
        if (w_take) begin
            r_tok <= '{found: 1'b1, delta: r_d};
            r_idx <= IDX_W'(POS);
        end else begin
            r_tok <= i_tok;
            r_idx <= i_tok_idx;
        end
    end

    assign o_stamp   = r_stamp;
    assign o_old     = r_old;
    assign o_tok     = r_tok;
    assign o_tok_idx = r_idx;

endmodule

// ===== hdl/tem_ctrl.sv =====
// Sequencer for the matcher: admission, front expiry, match scan, counters,
// configuration registers and the output register. Uses tem_pkg.
module tem_ctrl #(
    parameter  int unsigned DEPTH = tem_pkg::QUEUE_DEPTH_DEF,
    localparam int unsigned IDX_W = $clog2(DEPTH),
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  tem_pkg::t_tem_req             i_req,
    output logic                          o_valid,
    input  logic                          i_stall,
    output tem_pkg::t_tem_rsp             o_rsp,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tem_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output tem_pkg::t_cell_ctl            o_ctl,
    output logic [CNT_W-1:0]              o_cnt,
    output logic [IDX_W-1:0]              o_rm_pos,
    input  logic                          i_front_old,
    input  tem_pkg::t_tok                 i_tok,
    input  logic [IDX_W-1:0]              i_tok_idx
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETTLE = 3'd1;
    localparam logic [2:0] S_EXP    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_type, n_type;
    logic [63:0]       r_now, n_now;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_exp, n_exp;
    logic              r_admit, n_admit;
    logic              r_drop, n_drop;
    logic              r_match, n_match;
    logic [31:0]       r_delta, n_delta;
    logic [IDX_W-1:0]  r_scan, n_scan;
    logic [31:0]       r_matched_total, n_matched_total;
    logic [31:0]       r_expired_total, n_expired_total;
    logic [31:0]       r_unmatched_total, n_unmatched_total;
    logic [31:0]       r_window, n_window;
    logic              r_ctx_only, n_ctx_only;
    logic              r_out_valid, n_out_valid;
    tem_pkg::t_tem_rsp r_out, n_out;

    logic              w_accept;
    logic              w_out_free;
    logic              w_src_ok;
    logic              w_shift;
    logic              w_write;
    logic [IDX_W-1:0]  w_rm_pos;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_src_ok   = r_ctx_only ? i_req.context_allowed
                      : (i_req.context_allowed && (i_req.player_moving || i_req.moved_recently));

    always_comb begin
        n_state           = r_state;
        n_type            = r_type;
        n_now             = r_now;
        n_cnt             = r_cnt;
        n_exp             = r_exp;
        n_admit           = r_admit;
        n_drop            = r_drop;
        n_match           = r_match;
        n_delta           = r_delta;
        n_scan            = r_scan;
        n_matched_total   = r_matched_total;
        n_expired_total   = r_expired_total;
        n_unmatched_total = r_unmatched_total;
        n_window          = r_window;
        n_ctx_only        = r_ctx_only;
        n_out_valid       = r_out_valid && i_stall;
        n_out             = r_out;
        w_shift           = 1'b0;
        w_write           = 1'b0;
        w_rm_pos          = '0;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tem_pkg::CFG_MATCH_WINDOW: n_window   = i_cfg_data;
                tem_pkg::CFG_CONTEXT_ONLY: n_ctx_only = i_cfg_data[0];
                default:                   n_window   = r_window;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_type  = i_req.req_type;
                    n_now   = i_req.timestamp_us;
                    n_exp   = '0;
                    n_admit = 1'b0;
                    n_drop  = 1'b0;
                    n_match = 1'b0;
                    n_delta = '0;
                    unique case (i_req.req_type)
                        tem_pkg::REQ_SOURCE: n_state = w_src_ok ? S_SETTLE : S_FIN;
                        tem_pkg::REQ_RENDER:
                            n_state = (i_req.timestamp_us != 64'd0) ? S_SETTLE : S_FIN;
                        tem_pkg::REQ_TICK:   n_state = S_SETTLE;
                        default:             n_state = S_FIN;
                    endcase
                end
            end
            S_SETTLE: begin
                n_state = S_EXP;
            end
            S_EXP: begin
                if ((r_cnt != '0) && i_front_old) begin
                    w_shift         = 1'b1;
                    n_cnt           = r_cnt - 1'b1;
                    n_exp           = r_exp + 1'b1;
                    n_expired_total = r_expired_total + 32'd1;
                    n_state         = S_SETTLE;
                end else begin
                    unique case (r_type)
                        tem_pkg::REQ_SOURCE: begin
                            if (r_cnt < CNT_W'(DEPTH)) begin
                                w_write = 1'b1;
                                n_cnt   = r_cnt + 1'b1;
                                n_admit = 1'b1;
                            end else begin
                                n_drop  = 1'b1;
                            end
                            n_state = S_FIN;
                        end
                        tem_pkg::REQ_RENDER: begin
                            n_scan  = '0;
                            n_state = S_SCAN;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_scan == IDX_W'(DEPTH - 1)) begin
                    if (i_tok.found) begin
                        w_shift         = 1'b1;
                        w_rm_pos        = i_tok_idx;
                        n_cnt           = r_cnt - 1'b1;
                        n_match         = 1'b1;
                        n_delta         = i_tok.delta;
                        n_matched_total = r_matched_total + 32'd1;
                    end else begin
                        n_unmatched_total = r_unmatched_total + 32'd1;
                    end
                    n_state = S_FIN;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{
                        admitted:        r_admit,
                        queue_full_drop: r_drop,
                        matched:         r_match,
                        match_delta_us:  r_delta,
                        expired_now:     5'(r_exp),
                        pending_after:   5'(r_cnt),
                        matched_total:   r_matched_total,
                        expired_total:   r_expired_total,
                        unmatched_total: r_unmatched_total
                    };
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_cnt             <= '0;
            r_matched_total   <= '0;
            r_expired_total   <= '0;
            r_unmatched_total <= '0;
            r_window          <= tem_pkg::MATCH_WINDOW_RST;
            r_ctx_only        <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_state           <= n_state;
            r_cnt             <= n_cnt;
            r_matched_total   <= n_matched_total;
            r_expired_total   <= n_expired_total;
            r_unmatched_total <= n_unmatched_total;
            r_window          <= n_window;
            r_ctx_only        <= n_ctx_only;
            r_out_valid       <= n_out_valid;
        end
        r_type  <= n_type;
        r_now   <= n_now;
        r_exp   <= n_exp;
        r_admit <= n_admit;
        r_drop  <= n_drop;
        r_match <= n_match;
        r_delta <= n_delta;
        r_scan  <= n_scan;
        r_out   <= n_out;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_rsp       = r_out;
    assign o_cfg_ready = 1'b1;
    assign o_ctl       = '{shift: w_shift, write: w_write, now: r_now, window: r_window};
    assign o_cnt       = r_cnt;
    assign o_rm_pos    = w_rm_pos;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("pending count above queue depth");

    a_shift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |-> (r_cnt != '0))
        else $error("entry removed from an empty queue");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_write |-> (r_cnt < CNT_W'(DEPTH)))
        else $error("entry appended to a full queue");

    a_expire_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP && w_shift) |=>
            (r_expired_total == $past(r_expired_total) + 32'd1))
        else $error("expired total out of step with front pops");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted request left the sequencer idle");

endmodule

// ===== hdl/timestamp_event_matcher.sv =====
// Sequence: admitted or dropped sources and ticks pass a settle step and an expiry decision,
//   repeated after each front pop, then the finish step; a stamped render adds the match
//   scan across the cell chain; any other request goes straight to the finish step.
// Throughput: one request at a time; the next request is taken the cycle after the previous
//   result enters the output register, so the match scan across the cell chain sets render rate.
// Reset (i_rst_n low, synchronous): queue empty, counters zero, match window 80000 us,
//   context-only mode off, no result pending. Stored stamps are not cleared.
module timestamp_event_matcher #(
    parameter int unsigned QUEUE_DEPTH = tem_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  tem_pkg::t_tem_req             i_req,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output tem_pkg::t_tem_rsp             o_rsp,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tem_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    // The pending queue is a row of cells, cell 0 at the front. Removing an
    // entry makes every cell at or past the removed slot take its right
    // neighbor's stamp at once; appending writes the cell at the tail.
    tem_pkg::t_cell_ctl w_ctl;
    logic [CNT_W-1:0]   w_cnt;
    logic [IDX_W-1:0]   w_rm_pos;

    logic [63:0]        w_stamp [QUEUE_DEPTH];
    logic               w_old   [QUEUE_DEPTH];

    // Best-candidate token walks left to right, one cell per cycle. Each cell
    // replaces it only on a strictly smaller delta, so the earliest entry wins
    // ties. The sequencer reads the winner from the last cell as its scan ends.
    tem_pkg::t_tok      w_tok     [QUEUE_DEPTH + 1];
    logic [IDX_W-1:0]   w_tok_idx [QUEUE_DEPTH + 1];

    assign w_tok[0]     = '{found: 1'b0, delta: 32'd0};
    assign w_tok_idx[0] = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [63:0] w_next;

        // the last cell pulls in an empty slot on a shift
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next = 64'd0;
        end else begin : g_body
            assign w_next = w_stamp[g + 1];
        end

        tem_cell #(
            .DEPTH (QUEUE_DEPTH),
            .POS   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_cnt        (w_cnt),
            .i_rm_pos     (w_rm_pos),
            .i_next_stamp (w_next),
            .o_stamp      (w_stamp[g]),
            .o_old        (w_old[g]),
            .i_tok        (w_tok[g]),
            .i_tok_idx    (w_tok_idx[g]),
            .o_tok        (w_tok[g + 1]),
            .o_tok_idx    (w_tok_idx[g + 1])
        );
    end

    // Sequencer: expiry pops only look at the front cell's registered flag,
    // so each pop is followed by a settle state before the next decision.
    tem_ctrl #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ctl       (w_ctl),
        .o_cnt       (w_cnt),
        .o_rm_pos    (w_rm_pos),
        .i_front_old (w_old[0]),
        .i_tok       (w_tok[QUEUE_DEPTH]),
        .i_tok_idx   (w_tok_idx[QUEUE_DEPTH])
    );

endmodule

// ===== bench/tem_checker.sv =====
// Scoreboard for timestamp_event_matcher: predicts every result and compares it.
// Depends on tem_pkg for the request, result and register encodings.
module tem_checker
    import tem_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_stall,
    input  t_tem_req             i_req,
    input  logic                 i_rsp_valid,
    input  logic                 i_rsp_stall,
    input  t_tem_rsp             i_rsp,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output int unsigned          o_fail_count,
    output int unsigned          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // the block holds at most one request in work and one result in its output register
    localparam int unsigned AWAIT_DEPTH = 8;

    logic [63:0] held_stamp [QUEUE_DEPTH];
    int unsigned held_n;
    logic [31:0] matched_cnt;
    logic [31:0] expired_cnt;
    logic [31:0] unmatched_cnt;
    logic [31:0] window_us;
    logic        ctx_only;
    int unsigned fails = 0;
    t_tem_rsp    awaited_rsp [AWAIT_DEPTH];
    int unsigned await_rd = 0;
    int unsigned await_wr = 0;
    int unsigned await_cnt = 0;

    function automatic void drop_entry(int unsigned pos);
        for (int unsigned k = pos; k + 1 < held_n; k++) begin
            held_stamp[k] = held_stamp[k + 1];
        end
        held_n--;
    endfunction

    // Pop stale entries from the front; a zero or not-yet-old front entry stops it.
    function automatic int unsigned age_out(logic [63:0] now);
        int unsigned n = 0;
        while (held_n > 0 && held_stamp[0] != 64'd0 && now > held_stamp[0]
               && (now - held_stamp[0]) > {32'd0, window_us}) begin
            drop_entry(0);
            expired_cnt++;
            n++;
        end
        return n;
    endfunction

    function automatic t_tem_rsp correlate(t_tem_req req);
        t_tem_rsp    r;
        logic [63:0] now;
        logic [63:0] ts;
        logic [63:0] d;
        logic [63:0] best_d;
        int unsigned best;
        logic        found;
        r = '0;
        now = req.timestamp_us;
        case (req.req_type)
            REQ_SOURCE: begin
                if (req.context_allowed
                    && (ctx_only || req.player_moving || req.moved_recently)) begin
                    r.expired_now = 5'(age_out(now));
                    if (held_n < QUEUE_DEPTH) begin
                        held_stamp[held_n] = now;
                        held_n++;
                        r.admitted = 1'b1;
                    end else begin
                        r.queue_full_drop = 1'b1;
                    end
                end
            end
            REQ_RENDER: begin
                if (now != 64'd0) begin
                    r.expired_now = 5'(age_out(now));
                    found = 1'b0;
                    best = 0;
                    best_d = '1;
                    for (int unsigned k = 0; k < held_n; k++) begin
                        ts = held_stamp[k];
                        if (ts != 64'd0 && now >= ts) begin
                            d = now - ts;
                            // strict compare keeps the earliest entry on ties
                            if (d <= {32'd0, window_us} && d < best_d) begin
                                best_d = d;
                                best = k;
                                found = 1'b1;
                            end
                        end
                    end
                    if (found) begin
                        drop_entry(best);
                        matched_cnt++;
                        r.matched = 1'b1;
                        r.match_delta_us = (best_d > 64'hFFFF_FFFF) ? '1 : best_d[31:0];
                    end else begin
                        unmatched_cnt++;
                    end
                end
            end
            REQ_TICK: begin
                r.expired_now = 5'(age_out(now));
            end
            default: begin
            end
        endcase
        r.pending_after = 5'(held_n);
        r.matched_total = matched_cnt;
        r.expired_total = expired_cnt;
        r.unmatched_total = unmatched_cnt;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    function automatic void compare_rsp(t_tem_rsp want, t_tem_rsp got);
        check_field("admitted", 32'(want.admitted), 32'(got.admitted));
        check_field("queue_full_drop", 32'(want.queue_full_drop), 32'(got.queue_full_drop));
        check_field("matched", 32'(want.matched), 32'(got.matched));
        check_field("match_delta_us", want.match_delta_us, got.match_delta_us);
        check_field("expired_now", 32'(want.expired_now), 32'(got.expired_now));
        check_field("pending_after", 32'(want.pending_after), 32'(got.pending_after));
        check_field("matched_total", want.matched_total, got.matched_total);
        check_field("expired_total", want.expired_total, got.expired_total);
        check_field("unmatched_total", want.unmatched_total, got.unmatched_total);
    endfunction

    // Results are retired before the request of the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_n = 0;
            matched_cnt = '0;
            expired_cnt = '0;
            unmatched_cnt = '0;
            window_us = MATCH_WINDOW_RST;
            ctx_only = 1'b0;
            for (int unsigned k = 0; k < QUEUE_DEPTH; k++) begin
                held_stamp[k] = '0;
            end
            await_rd = 0;
            await_wr = 0;
            await_cnt = 0;
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (await_cnt == 0) begin
                    $error("result with no request outstanding");
                    fails++;
                end else begin
                    compare_rsp(awaited_rsp[await_rd], i_rsp);
                    await_rd = (await_rd + 1) % AWAIT_DEPTH;
                    await_cnt--;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MATCH_WINDOW: window_us = i_cfg_data;
                    CFG_CONTEXT_ONLY: ctx_only = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_req_valid && !i_req_stall) begin
                if (await_cnt == AWAIT_DEPTH) begin
                    $error("more requests in flight than the block can hold");
                    fails++;
                end else begin
                    awaited_rsp[await_wr] = correlate(i_req);
                    await_wr = (await_wr + 1) % AWAIT_DEPTH;
                    await_cnt++;
                end
            end
        end
        o_outstanding <= await_cnt;
        o_fail_count <= fails;
    end

endmodule

// ===== bench/tb_timestamp_event_matcher.sv =====
// Top of the timestamp_event_matcher testbench: clock, reset, stimulus and verdict.
// Depends on tem_pkg, the block itself and the tem_checker scoreboard.
module tb_timestamp_event_matcher;
    import tem_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // request type that the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned ITEMS_PER_PHASE = 190;
    localparam int unsigned PHASES = 8;
    // wait before the verdict so a stray result can still show up
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned QUIET_LIMIT = 5000;

    typedef enum {MIX_SOURCE_HEAVY, MIX_BALANCED, MIX_RENDER_HEAVY} t_mix;
    typedef enum {STALL_NONE, STALL_CHOPPY, STALL_CLOGGED, STALL_ALTERNATE} t_stall_style;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_tem_req             i_req = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_tem_rsp             o_rsp;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    int unsigned fail_count;
    int unsigned rsp_outstanding;
    int unsigned quiet_cycles = 0;

    // stimulus time base and the window the block currently holds
    logic [63:0] stamp_now = 64'd1000;
    logic [31:0] cur_window = MATCH_WINDOW_RST;

    t_stall_style stall_style = STALL_NONE;
    int unsigned  stall_left = 0;

    timestamp_event_matcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    tem_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_req         (i_req),
        .i_rsp_valid   (o_valid),
        .i_rsp_stall   (i_stall),
        .i_rsp         (o_rsp),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (rsp_outstanding)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Result-side backpressure: pick a new random style whenever the current run ends, so
    // stalls land on every stage of the block's work, with free-flowing stretches in between.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style <= t_stall_style'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            STALL_NONE:      i_stall <= 1'b0;
            STALL_CHOPPY:    i_stall <= ($urandom_range(0, 2) == 0);
            STALL_CLOGGED:   i_stall <= ($urandom_range(0, 7) != 0);
            STALL_ALTERNATE: i_stall <= ~i_stall;
            default:         i_stall <= 1'b0;
        endcase
    end

    // Watchdog: count cycles in which no channel moves anything.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_timestamp_event_matcher: errors");
        $finish;
    end

    function automatic t_tem_req build_request(logic [1:0] kind, logic [63:0] ts,
                                               logic ctx, logic moving, logic recent);
        t_tem_req r;
        r.req_type = kind;
        r.timestamp_us = ts;
        r.context_allowed = ctx;
        r.player_moving = moving;
        r.moved_recently = recent;
        return r;
    endfunction

    // Random request around the running time base. Source stamps stay nonzero and close
    // to the base: a zero or far-future source would sit at the front of the queue for
    // good and block expiry for the rest of the run.
    function automatic t_tem_req random_request(t_mix mix);
        t_tem_req    r;
        int unsigned roll;
        int unsigned sel;
        int unsigned step_max;
        int unsigned src_pct;
        int unsigned rnd_end;
        r = '0;
        // the source-heavy mix moves time slowly so the queue fills up
        step_max = (mix == MIX_SOURCE_HEAVY) ? (cur_window >> 6) + 4 : (cur_window >> 3) + 4;
        src_pct = (mix == MIX_SOURCE_HEAVY) ? 75 : (mix == MIX_BALANCED) ? 45 : 25;
        rnd_end = (mix == MIX_SOURCE_HEAVY) ? 93 : 85;
        r.context_allowed = ($urandom_range(0, 7) != 0);
        r.player_moving = 1'($urandom_range(0, 1));
        r.moved_recently = 1'($urandom_range(0, 1));
        // advance the base; a held base gives equal stamps and thus ties
        if ($urandom_range(0, 9) != 0) begin
            stamp_now += $urandom_range(0, step_max);
        end
        roll = $urandom_range(0, 99);
        sel = $urandom_range(0, 39);
        if (roll < src_pct) begin
            r.req_type = REQ_SOURCE;
            if (sel < 34 || stamp_now <= 64'(step_max)) begin
                r.timestamp_us = stamp_now;
            end else if (sel < 38) begin
                r.timestamp_us = stamp_now - $urandom_range(1, step_max);
            end else begin
                r.timestamp_us = stamp_now + $urandom_range(1, step_max);
            end
        end else if (roll < rnd_end) begin
            r.req_type = REQ_RENDER;
            if (sel < 36 || stamp_now <= 64'(step_max)) begin
                r.timestamp_us = stamp_now;
            end else if (sel < 38) begin
                r.timestamp_us = stamp_now - $urandom_range(1, step_max);
            end else if (sel < 39) begin
                r.timestamp_us = '0;
            end else begin
                r.timestamp_us = {$urandom(), $urandom()};
            end
        end else if (roll < 98) begin
            r.req_type = REQ_TICK;
            if (sel < 28) begin
                // jump past the window so older entries fall out
                stamp_now += 64'(cur_window) + 64'($urandom_range(0, (cur_window >> 2) + 8));
                r.timestamp_us = stamp_now;
            end else if (sel < 36) begin
                r.timestamp_us = stamp_now;
            end else if (sel < 38) begin
                r.timestamp_us = '0;
            end else begin
                r.timestamp_us = {$urandom(), $urandom()};
            end
        end else begin
            r.req_type = REQ_UNUSED;
            r.timestamp_us = {$urandom(), $urandom()};
        end
        return r;
    endfunction

    // Present one request and hold it until the block takes it. Valid is left high so a
    // back-to-back request needs no second assignment in the same step.
    task automatic send_request(t_tem_req r);
        i_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (rsp_outstanding != 0);
    endtask

    // Write both registers back to back; only bit 0 of the mode word is meaningful,
    // so the upper bits carry noise.
    task automatic write_config(logic [31:0] window, logic mode);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MATCH_WINDOW;
        i_cfg_data <= window;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_CONTEXT_ONLY;
        i_cfg_data <= ($urandom() & ~32'd1) | {31'd0, mode};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_window = window;
    endtask

    initial begin
        logic [63:0] base;
        logic [31:0] win;
        logic        mode;
        t_mix        mix;
        int unsigned burst_left;
        int unsigned gap;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, running on the reset register values (window 80000, movement
        // required). Empty queue, unstamped and unknown requests first.
        send_request(build_request(REQ_RENDER, 64'd1000, 1'b1, 1'b1, 1'b1));
        send_request(build_request(REQ_RENDER, 64'd0, 1'b1, 1'b1, 1'b1));
        send_request(build_request(REQ_UNUSED, '1, 1'b1, 1'b1, 1'b1));
        send_request(build_request(REQ_TICK, 64'd0, 1'b0, 1'b0, 1'b0));
        // admission: no context, then context without movement, then each movement flag
        send_request(build_request(REQ_SOURCE, 64'd1000, 1'b0, 1'b1, 1'b1));
        send_request(build_request(REQ_SOURCE, 64'd1000, 1'b1, 1'b0, 1'b0));
        send_request(build_request(REQ_SOURCE, 64'd1000, 1'b1, 1'b1, 1'b0));
        send_request(build_request(REQ_SOURCE, 64'd1000, 1'b1, 1'b0, 1'b1));
        send_request(build_request(REQ_SOURCE, 64'd1500, 1'b1, 1'b1, 1'b1));
        // tie at delta zero goes to the older entry; a future entry is skipped
        send_request(build_request(REQ_RENDER, 64'd1000, 1'b0, 1'b0, 1'b0));
        send_request(build_request(REQ_RENDER, 64'd1200, 1'b0, 1'b0, 1'b0));
        // age equal to the window still matches
        send_request(build_request(REQ_RENDER, 64'd81500, 1'b0, 1'b0, 1'b0));
        // one past the window expires before the match scan
        send_request(build_request(REQ_SOURCE, 64'd2000, 1'b1, 1'b1, 1'b0));
        send_request(build_request(REQ_RENDER, 64'd82001, 1'b0, 1'b0, 1'b0));
        // tick expiry right at and one past the window edge
        send_request(build_request(REQ_SOURCE, 64'd100000, 1'b1, 1'b0, 1'b1));
        send_request(build_request(REQ_TICK, 64'd180000, 1'b0, 1'b0, 1'b0));
        send_request(build_request(REQ_TICK, 64'd180001, 1'b0, 1'b0, 1'b0));
        send_request(build_request(REQ_RENDER, '1, 1'b1, 1'b1, 1'b1));
        drain();

        // Random phases, each with its own register setting and traffic mix. All results
        // are drained before every register write.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin win = 32'd0;         mode = 1'b0; mix = MIX_BALANCED;     end
                1: begin win = 32'hFFFF_FFFF; mode = 1'b1; mix = MIX_SOURCE_HEAVY; end
                2: begin win = 32'd1;         mode = 1'b0; mix = MIX_RENDER_HEAVY; end
                3: begin win = 32'd500;       mode = 1'b1; mix = MIX_SOURCE_HEAVY; end
                4: begin win = 32'd80000;     mode = 1'b0; mix = MIX_BALANCED;     end
                5: begin
                    win = $urandom();
                    mode = 1'($urandom_range(0, 1));
                    mix = t_mix'($urandom_range(0, 2));
                end
                6: begin
                    win = $urandom_range(0, 5000);
                    mode = 1'($urandom_range(0, 1));
                    mix = t_mix'($urandom_range(0, 2));
                end
                default: begin win = 32'hFFFF_FFFF; mode = 1'b0; mix = MIX_BALANCED; end
            endcase
            if (p == 0) begin
                stamp_now = 64'd200000;
            end else if (p == PHASES - 1) begin
                // last phase runs near the top of the stamp range; time never wraps
                stamp_now = 64'hFFFF_FF00_0000_0000;
            end
            write_config(win, mode);
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    if (gap != 0) begin
                        i_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                send_request(random_request(mix));
                burst_left--;
            end
            drain();
        end

        // Closing directed part: zero-stamp source and a full queue. Kept for the end
        // because a zero entry never leaves and blocks front expiry from then on.
        write_config(32'd80000, 1'b1);
        base = stamp_now + (64'd1 << 34);
        send_request(build_request(REQ_TICK, base, 1'b0, 1'b0, 1'b0));
        // context alone admits in context-only mode
        send_request(build_request(REQ_SOURCE, 64'd0, 1'b1, 1'b0, 1'b0));
        send_request(build_request(REQ_SOURCE, base, 1'b1, 1'b0, 1'b0));
        send_request(build_request(REQ_TICK, base + (64'd1 << 20), 1'b0, 1'b0, 1'b0));
        send_request(build_request(REQ_RENDER, base + 64'd100, 1'b0, 1'b0, 1'b0));
        send_request(build_request(REQ_RENDER, base + 64'd200, 1'b0, 1'b0, 1'b0));
        send_request(build_request(REQ_RENDER, '1, 1'b0, 1'b0, 1'b0));
        // fill to the limit, then overflow
        for (int n = 0; n < QUEUE_DEPTH_DEF; n++) begin
            send_request(build_request(REQ_SOURCE, base + 64'd300, 1'b1, 1'b1, 1'b1));
        end
        send_request(build_request(REQ_SOURCE, base + 64'd300, 1'b0, 1'b1, 1'b1));
        send_request(build_request(REQ_RENDER, base + 64'd300, 1'b1, 1'b1, 1'b1));
        drain();

        // let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_timestamp_event_matcher: clean");
        end else begin
            $display("tb_timestamp_event_matcher: errors");
        end
        $finish;
    end

endmodule
